>>> rtl/s5ch_pkg.sv
package s5ch_pkg;

    localparam int MaxTx      = 7;
    localparam int QueueDepth = 2;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'd0,
        PH_GVER  = 5'd1,
        PH_GMETH = 5'd2,
        PH_USER  = 5'd3,
        PH_PASS  = 5'd4,
        PH_AVER  = 5'd5,
        PH_AST   = 5'd6,
        PH_DEST  = 5'd7,
        PH_RVER  = 5'd8,
        PH_REP   = 5'd9,
        PH_RRSV  = 5'd10,
        PH_RATYP = 5'd11,
        PH_RLEN  = 5'd12,
        PH_RADDR = 5'd13,
        PH_RPORT = 5'd14,
        PH_DONE  = 5'd15,
        PH_ERR   = 5'd16
    } phase_t;

    // input kinds
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_SERVER  = 2'd1;
    localparam logic [1:0] OP_PAYLOAD = 2'd2;

    // next expected item
    localparam logic [1:0] WANT_SERVER  = 2'd0;
    localparam logic [1:0] WANT_PAYLOAD = 2'd1;
    localparam logic [1:0] WANT_NONE    = 2'd2;

    // status codes
    localparam logic [3:0] ST_BUSY        = 4'd0;
    localparam logic [3:0] ST_CONNECTED   = 4'd1;
    localparam logic [3:0] ST_UNEXPECTED  = 4'd2;
    localparam logic [3:0] ST_NO_METHOD   = 4'd3;
    localparam logic [3:0] ST_NEED_CREDS  = 4'd4;
    localparam logic [3:0] ST_BAD_METHOD  = 4'd5;
    localparam logic [3:0] ST_AUTH_REFUSE = 4'd6;
    localparam logic [3:0] ST_CONN_REFUSE = 4'd7;
    localparam logic [3:0] ST_MISUSE      = 4'd8;

    // configuration register indexes
    localparam logic [2:0] CFG_HAS_CREDS = 3'd0;
    localparam logic [2:0] CFG_KIND      = 3'd1;
    localparam logic [2:0] CFG_PORT      = 3'd2;
    localparam logic [2:0] CFG_USER_LEN  = 3'd3;
    localparam logic [2:0] CFG_PASS_LEN  = 3'd4;
    localparam logic [2:0] CFG_HOST_LEN  = 3'd5;

    // destination kinds
    localparam logic [1:0] KIND_HOST = 2'd0;
    localparam logic [1:0] KIND_IPV4 = 2'd1;
    localparam logic [1:0] KIND_IPV6 = 2'd2;

    // protocol bytes
    localparam logic [7:0] B_VERSION   = 8'h05;
    localparam logic [7:0] B_AUTH_VER  = 8'h01;
    localparam logic [7:0] B_CMD_CONN  = 8'h01;
    localparam logic [7:0] B_ZERO      = 8'h00;
    localparam logic [7:0] B_M_NONE    = 8'h00;
    localparam logic [7:0] B_M_USERPW  = 8'h02;
    localparam logic [7:0] B_M_REJECT  = 8'hFF;
    localparam logic [7:0] B_AT_IPV4   = 8'h01;
    localparam logic [7:0] B_AT_HOST   = 8'h03;
    localparam logic [7:0] B_AT_IPV6   = 8'h04;
    localparam logic [7:0] B_ONE_COUNT = 8'h01;
    localparam logic [7:0] B_TWO_COUNT = 8'h02;

    typedef struct packed {
        logic [MaxTx-1:0][7:0] bytes;
        logic [2:0]            count;   // 0: one result with no byte
        logic [1:0]            want;
        logic [3:0]            status;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] index;
        logic [15:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> rtl/s5ch_front.sv
module s5ch_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  s5ch_pkg::cfg_wr_t   cfg_wr,
    input  logic                push,
    input  logic [1:0]          op,
    input  logic [7:0]          data,
    output s5ch_pkg::cmd_t      cmd
);

    logic                   has_creds_reg;
    logic [1:0]             kind_reg;
    logic [15:0]            port_reg;
    logic [7:0]             user_len_reg;
    logic [7:0]             pass_len_reg;
    logic [7:0]             host_len_reg;

    s5ch_pkg::phase_t       phase_reg, phase_next;
    logic [7:0]             rem_reg, rem_next;
    logic [3:0]             outcome_reg, outcome_next;

    logic                   finished;
    logic [7:0]             rem_dec;
    logic [7:0]             req_count;
    logic                   go_request;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_creds_reg <= 1'b0;
            kind_reg      <= s5ch_pkg::KIND_IPV4;
            port_reg      <= '0;
            user_len_reg  <= '0;
            pass_len_reg  <= '0;
            host_len_reg  <= '0;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                s5ch_pkg::CFG_HAS_CREDS: has_creds_reg <= cfg_wr.data[0];
                s5ch_pkg::CFG_KIND:      kind_reg      <= cfg_wr.data[1:0];
                s5ch_pkg::CFG_PORT:      port_reg      <= cfg_wr.data;
                s5ch_pkg::CFG_USER_LEN:  user_len_reg  <= cfg_wr.data[7:0];
                s5ch_pkg::CFG_PASS_LEN:  pass_len_reg  <= cfg_wr.data[7:0];
                s5ch_pkg::CFG_HOST_LEN:  host_len_reg  <= cfg_wr.data[7:0];
                default: ;
            endcase
        end
    end

    assign finished = (phase_reg == s5ch_pkg::PH_DONE) || (phase_reg == s5ch_pkg::PH_ERR);
    assign rem_dec  = rem_reg - 8'd1;

    always_comb
    begin
        case (kind_reg)
            s5ch_pkg::KIND_HOST: req_count = host_len_reg;
            s5ch_pkg::KIND_IPV4: req_count = 8'd4;
            default:             req_count = 8'd16;
        endcase
    end

    // the connect request goes out after method "none" or after auth success
    always_comb
    begin
        go_request = 1'b0;
        if (op == s5ch_pkg::OP_SERVER)
        begin
            if (phase_reg == s5ch_pkg::PH_GMETH && data == s5ch_pkg::B_M_NONE)
                go_request = 1'b1;
            if (phase_reg == s5ch_pkg::PH_AST && data == s5ch_pkg::B_ZERO)
                go_request = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        rem_next     = rem_reg;
        outcome_next = outcome_reg;
        if (!finished)
        begin
            case (op)
                s5ch_pkg::OP_START:
                begin
                    if (phase_reg == s5ch_pkg::PH_IDLE)
                        phase_next = s5ch_pkg::PH_GVER;
                    else
                    begin
                        phase_next   = s5ch_pkg::PH_ERR;
                        outcome_next = s5ch_pkg::ST_MISUSE;
                    end
                end
                s5ch_pkg::OP_SERVER:
                begin
                    case (phase_reg)
                        s5ch_pkg::PH_GVER:
                        begin
                            if (data != s5ch_pkg::B_VERSION)
                            begin
                                phase_next   = s5ch_pkg::PH_ERR;
                                outcome_next = s5ch_pkg::ST_UNEXPECTED;
                            end
                            else
                                phase_next = s5ch_pkg::PH_GMETH;
                        end
                        s5ch_pkg::PH_GMETH:
                        begin
                            if (data == s5ch_pkg::B_M_REJECT)
                            begin
                                phase_next   = s5ch_pkg::PH_ERR;
                                outcome_next = s5ch_pkg::ST_NO_METHOD;
                            end
                            else if (data == s5ch_pkg::B_M_USERPW)
                            begin
                                if (!has_creds_reg)
                                begin
                                    phase_next   = s5ch_pkg::PH_ERR;
                                    outcome_next = s5ch_pkg::ST_NEED_CREDS;
                                end
                                else if (user_len_reg != 8'd0)
                                begin
                                    phase_next = s5ch_pkg::PH_USER;
                                    rem_next   = user_len_reg;
                                end
                                else if (pass_len_reg != 8'd0)
                                begin
                                    phase_next = s5ch_pkg::PH_PASS;
                                    rem_next   = pass_len_reg;
                                end
                                else
                                    phase_next = s5ch_pkg::PH_AVER;
                            end
                            else if (data != s5ch_pkg::B_M_NONE)
                            begin
                                phase_next   = s5ch_pkg::PH_ERR;
                                outcome_next = s5ch_pkg::ST_BAD_METHOD;
                            end
                        end
                        s5ch_pkg::PH_AVER:
                        begin
                            if (data != s5ch_pkg::B_AUTH_VER)
                            begin
                                phase_next   = s5ch_pkg::PH_ERR;
                                outcome_next = s5ch_pkg::ST_UNEXPECTED;
                            end
                            else
                                phase_next = s5ch_pkg::PH_AST;
                        end
                        s5ch_pkg::PH_AST:
                        begin
                            if (data != s5ch_pkg::B_ZERO)
                            begin
                                phase_next   = s5ch_pkg::PH_ERR;
                                outcome_next = s5ch_pkg::ST_AUTH_REFUSE;
                            end
                        end
                        s5ch_pkg::PH_RVER:
                        begin
                            if (data != s5ch_pkg::B_VERSION)
                            begin
                                phase_next   = s5ch_pkg::PH_ERR;
                                outcome_next = s5ch_pkg::ST_UNEXPECTED;
                            end
                            else
                                phase_next = s5ch_pkg::PH_REP;
                        end
                        s5ch_pkg::PH_REP:
                        begin
                            if (data != s5ch_pkg::B_ZERO)
                            begin
                                phase_next   = s5ch_pkg::PH_ERR;
                                outcome_next = s5ch_pkg::ST_CONN_REFUSE;
                            end
                            else
                                phase_next = s5ch_pkg::PH_RRSV;
                        end
                        s5ch_pkg::PH_RRSV:
                        begin
                            if (data != s5ch_pkg::B_ZERO)
                            begin
                                phase_next   = s5ch_pkg::PH_ERR;
                                outcome_next = s5ch_pkg::ST_UNEXPECTED;
                            end
                            else
                                phase_next = s5ch_pkg::PH_RATYP;
                        end
                        s5ch_pkg::PH_RATYP:
                        begin
                            if (data == s5ch_pkg::B_AT_IPV4)
                            begin
                                phase_next = s5ch_pkg::PH_RADDR;
                                rem_next   = 8'd4;
                            end
                            else if (data == s5ch_pkg::B_AT_IPV6)
                            begin
                                phase_next = s5ch_pkg::PH_RADDR;
                                rem_next   = 8'd16;
                            end
                            else if (data == s5ch_pkg::B_AT_HOST)
                                phase_next = s5ch_pkg::PH_RLEN;
                            else
                            begin
                                phase_next   = s5ch_pkg::PH_ERR;
                                outcome_next = s5ch_pkg::ST_UNEXPECTED;
                            end
                        end
                        s5ch_pkg::PH_RLEN:
                        begin
                            if (data == 8'd0)
                            begin
                                phase_next = s5ch_pkg::PH_RPORT;
                                rem_next   = 8'd2;
                            end
                            else
                            begin
                                phase_next = s5ch_pkg::PH_RADDR;
                                rem_next   = data;
                            end
                        end
                        s5ch_pkg::PH_RADDR:
                        begin
                            rem_next = rem_dec;
                            if (rem_dec == 8'd0)
                            begin
                                phase_next = s5ch_pkg::PH_RPORT;
                                rem_next   = 8'd2;
                            end
                        end
                        s5ch_pkg::PH_RPORT:
                        begin
                            rem_next = rem_dec;
                            if (rem_dec == 8'd0)
                            begin
                                phase_next   = s5ch_pkg::PH_DONE;
                                outcome_next = s5ch_pkg::ST_CONNECTED;
                            end
                        end
                        default:
                        begin
                            phase_next   = s5ch_pkg::PH_ERR;
                            outcome_next = s5ch_pkg::ST_MISUSE;
                        end
                    endcase

                    if (go_request)
                    begin
                        if (kind_reg != s5ch_pkg::KIND_HOST && kind_reg != s5ch_pkg::KIND_IPV4
                            && kind_reg != s5ch_pkg::KIND_IPV6)
                        begin
                            phase_next   = s5ch_pkg::PH_ERR;
                            outcome_next = s5ch_pkg::ST_MISUSE;
                        end
                        else if (req_count == 8'd0)
                            phase_next = s5ch_pkg::PH_RVER;
                        else
                        begin
                            phase_next = s5ch_pkg::PH_DEST;
                            rem_next   = req_count;
                        end
                    end
                end
                s5ch_pkg::OP_PAYLOAD:
                begin
                    if (phase_reg == s5ch_pkg::PH_USER || phase_reg == s5ch_pkg::PH_PASS
                        || phase_reg == s5ch_pkg::PH_DEST)
                    begin
                        rem_next = rem_dec;
                        if (rem_dec == 8'd0)
                        begin
                            if (phase_reg == s5ch_pkg::PH_USER)
                            begin
                                if (pass_len_reg == 8'd0)
                                    phase_next = s5ch_pkg::PH_AVER;
                                else
                                begin
                                    phase_next = s5ch_pkg::PH_PASS;
                                    rem_next   = pass_len_reg;
                                end
                            end
                            else if (phase_reg == s5ch_pkg::PH_PASS)
                                phase_next = s5ch_pkg::PH_AVER;
                            else
                                phase_next = s5ch_pkg::PH_RVER;
                        end
                    end
                    else
                    begin
                        phase_next   = s5ch_pkg::PH_ERR;
                        outcome_next = s5ch_pkg::ST_MISUSE;
                    end
                end
                default:
                begin
                    phase_next   = s5ch_pkg::PH_ERR;
                    outcome_next = s5ch_pkg::ST_MISUSE;
                end
            endcase
        end
    end

    // outputs: bytes to send, want and status after this item
    always_comb
    begin
        cmd = '0;
        if (!finished)
        begin
            case (op)
                s5ch_pkg::OP_START:
                begin
                    if (phase_reg == s5ch_pkg::PH_IDLE)
                    begin
                        cmd.bytes[0] = s5ch_pkg::B_VERSION;
                        cmd.bytes[1] = has_creds_reg ? s5ch_pkg::B_TWO_COUNT
                                                     : s5ch_pkg::B_ONE_COUNT;
                        cmd.bytes[2] = s5ch_pkg::B_M_NONE;
                        cmd.bytes[3] = s5ch_pkg::B_M_USERPW;
                        cmd.count    = has_creds_reg ? 3'd4 : 3'd3;
                    end
                end
                s5ch_pkg::OP_SERVER:
                begin
                    if (phase_reg == s5ch_pkg::PH_GMETH && data == s5ch_pkg::B_M_USERPW
                        && has_creds_reg)
                    begin
                        cmd.bytes[0] = s5ch_pkg::B_AUTH_VER;
                        cmd.bytes[1] = user_len_reg;
                        cmd.bytes[2] = pass_len_reg;
                        cmd.count    = (user_len_reg == 8'd0) ? 3'd3 : 3'd2;
                    end
                    else if (go_request)
                    begin
                        cmd.bytes[0] = s5ch_pkg::B_VERSION;
                        cmd.bytes[1] = s5ch_pkg::B_CMD_CONN;
                        cmd.bytes[2] = s5ch_pkg::B_ZERO;
                        case (kind_reg)
                            s5ch_pkg::KIND_HOST:
                            begin
                                cmd.bytes[3] = s5ch_pkg::B_AT_HOST;
                                cmd.bytes[4] = host_len_reg;
                                cmd.bytes[5] = port_reg[15:8];
                                cmd.bytes[6] = port_reg[7:0];
                                cmd.count    = (host_len_reg == 8'd0) ? 3'd7 : 3'd5;
                            end
                            s5ch_pkg::KIND_IPV4:
                            begin
                                cmd.bytes[3] = s5ch_pkg::B_AT_IPV4;
                                cmd.count    = 3'd4;
                            end
                            s5ch_pkg::KIND_IPV6:
                            begin
                                cmd.bytes[3] = s5ch_pkg::B_AT_IPV6;
                                cmd.count    = 3'd4;
                            end
                            default:
                                cmd.count = 3'd0;
                        endcase
                    end
                end
                s5ch_pkg::OP_PAYLOAD:
                begin
                    if (phase_reg == s5ch_pkg::PH_USER || phase_reg == s5ch_pkg::PH_PASS
                        || phase_reg == s5ch_pkg::PH_DEST)
                    begin
                        cmd.bytes[0] = data;
                        cmd.count    = 3'd1;
                        if (rem_dec == 8'd0)
                        begin
                            if (phase_reg == s5ch_pkg::PH_USER)
                            begin
                                cmd.bytes[1] = pass_len_reg;
                                cmd.count    = 3'd2;
                            end
                            else if (phase_reg == s5ch_pkg::PH_DEST)
                            begin
                                cmd.bytes[1] = port_reg[15:8];
                                cmd.bytes[2] = port_reg[7:0];
                                cmd.count    = 3'd3;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        case (phase_next)
            s5ch_pkg::PH_USER, s5ch_pkg::PH_PASS, s5ch_pkg::PH_DEST:
                cmd.want = s5ch_pkg::WANT_PAYLOAD;
            s5ch_pkg::PH_IDLE, s5ch_pkg::PH_DONE, s5ch_pkg::PH_ERR:
                cmd.want = s5ch_pkg::WANT_NONE;
            default:
                cmd.want = s5ch_pkg::WANT_SERVER;
        endcase
        if (phase_next == s5ch_pkg::PH_DONE || phase_next == s5ch_pkg::PH_ERR)
            cmd.status = outcome_next;
        else
            cmd.status = s5ch_pkg::ST_BUSY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= s5ch_pkg::PH_IDLE;
            rem_reg     <= '0;
            outcome_reg <= s5ch_pkg::ST_BUSY;
        end
        else if (push)
        begin
            phase_reg   <= phase_next;
            rem_reg     <= rem_next;
            outcome_reg <= outcome_next;
        end
    end

endmodule

>>> rtl/s5ch_queue.sv
module s5ch_queue
#(
    parameter int DEPTH = s5ch_pkg::QueueDepth
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  s5ch_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output s5ch_pkg::cmd_t      head,
    output s5ch_pkg::q_stat_t   stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    s5ch_pkg::cmd_t     mem [DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]      count_reg, count_next;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1))
            return '0;
        else
            return p + PW'(1);
    endfunction

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/s5ch_back.sv
module s5ch_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  s5ch_pkg::cmd_t      head,
    input  logic                head_valid,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    logic [2:0] beat_reg, beat_next;
    logic       last_beat;
    logic [7:0] tx_byte;

    assign last_beat = (head.count == 3'd0) || (beat_reg == head.count - 3'd1);
    assign tx_byte   = (head.count == 3'd0) ? 8'd0 : head.bytes[beat_reg];

    assign m_tvalid = head_valid;
    assign m_tdata  = {2'b00, head.status, head.want, tx_byte};
    assign m_tuser  = (head.count != 3'd0);
    assign m_tlast  = last_beat;
    assign pop      = head_valid && m_tready && last_beat;

    // advance through the bytes of the head entry, restart on the next one
    always_comb
    begin
        beat_next = beat_reg;
        if (head_valid && m_tready)
            beat_next = last_beat ? 3'd0 : beat_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_reg <= '0;
        else
            beat_reg <= beat_next;
    end

endmodule

>>> rtl/socks5_client_handshake.sv
// Client side of the SOCKS5 CONNECT handshake.
// Input stream (s_*): tuser carries the kind (start, server byte, payload
// byte), tdata the byte. Payload bytes are username, password, then the
// destination address. Output stream (m_*): one transfer per byte to send;
// an item that sends nothing gives one transfer with tuser low. tlast marks
// the final transfer caused by an input item; tdata also carries the next
// expected item and the status after that item.
// Configuration (cfg_*): index and data, always ready; write only while idle.
// Each result is registered in the command queue when its item is accepted.
// Throughput: one item per cycle while items give one transfer each and the
// output is not stalled; an item that sends n bytes gives n transfers, and
// the two-entry command queue between the decoder and the serializer
// absorbs the gap. When the receiver stalls, the queue fills and s_tready
// drops; nothing is lost. Reset returns to idle with default registers; the
// first error or the connected state is latched until reset.
module socks5_client_handshake
#(
    parameter int QUEUE_DEPTH = s5ch_pkg::QueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data
    input  logic [1:0]  s_tuser,    // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] tx_byte, [9:8] want, [13:10] status
    output logic        m_tuser,    // [0] tx_valid
    output logic        m_tlast,    // last_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    s5ch_pkg::cfg_wr_t  cfg_wr;
    s5ch_pkg::cmd_t     new_cmd;
    s5ch_pkg::cmd_t     head;
    s5ch_pkg::q_stat_t  q_stat;
    logic               push;
    logic               pop;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    s5ch_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .push   (push),
        .op     (s_tuser),
        .data   (s_tdata),
        .cmd    (new_cmd)
    );

    s5ch_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (new_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    s5ch_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!q_stat.empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

`ifndef SYNTHESIS
    a_no_byte_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("transfer without a byte is not the last of its run");

    a_final_want_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[13:10] != s5ch_pkg::ST_BUSY)
        |-> (m_tdata[9:8] == s5ch_pkg::WANT_NONE))
        else $error("final status with an item still expected");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !s_tready && m_tvalid)
        else $error("input taken while the command queue is full");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> m_tvalid)
        else $error("accepted item left no result pending");
`endif

endmodule

>>> verif/socks5_client_handshake_test.sv
`timescale 1ns / 1ps

module socks5_client_handshake_test;

    localparam int         StallLimit   = 4000;
    localparam int         HoldCycles   = 200;
    localparam int         SettleCycles = 8;
    localparam int         PrintLimit   = 20;
    localparam int         ItemTarget   = 100;
    localparam logic [1:0] OP_INVALID   = 2'd3;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic [1:0] want;
        logic [3:0] status;
        logic       is_last;
    } tx_result_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } item_t;

    typedef struct {
        logic [1:0] op;
        logic [7:0] data;
        bit         typed;
        logic [1:0] want;
        logic [3:0] status;
    } row_t;

    typedef enum int {
        FAULT_BAD_OP,
        FAULT_RESTART,
        FAULT_SWAP_OP,
        FAULT_BYTE
    } fault_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // handshake predictor: state and register copies
    s5ch_pkg::phase_t ph;
    logic [7:0]  left;
    logic [3:0]  latched;
    logic        cfg_creds;
    logic [1:0]  cfg_kind;
    logic [15:0] cfg_port;
    logic [7:0]  cfg_user_len;
    logic [7:0]  cfg_pass_len;
    logic [7:0]  cfg_host_len;
    logic [7:0]  out_bytes[$];
    int          step_results;

    tx_result_t  pending_tx[$];
    item_t       session_items[$];

    int  mismatches;
    int  items_sent;
    int  transfers_checked;
    int  cfg_writes;
    int  rx_wait;
    int  burst_left;
    bit  steady;
    bit  hold_req;

    row_t opening_rows[2] = '{
        '{s5ch_pkg::OP_START, 8'hFF, 1'b1, s5ch_pkg::WANT_SERVER, s5ch_pkg::ST_BUSY},
        '{s5ch_pkg::OP_SERVER, s5ch_pkg::B_VERSION, 1'b1, s5ch_pkg::WANT_SERVER,
          s5ch_pkg::ST_BUSY}
    };

    // everything after the handshake ends only repeats the latched status
    row_t closing_rows[4] = '{
        '{OP_INVALID, 8'h00, 1'b0, s5ch_pkg::WANT_NONE, s5ch_pkg::ST_BUSY},
        '{s5ch_pkg::OP_START, 8'hFF, 1'b0, s5ch_pkg::WANT_NONE, s5ch_pkg::ST_BUSY},
        '{s5ch_pkg::OP_PAYLOAD, 8'h80, 1'b0, s5ch_pkg::WANT_NONE, s5ch_pkg::ST_BUSY},
        '{s5ch_pkg::OP_SERVER, 8'h7F, 1'b0, s5ch_pkg::WANT_NONE, s5ch_pkg::ST_BUSY}
    };

    socks5_client_handshake u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void emit(input logic [7:0] b);
        if (out_bytes.size() < s5ch_pkg::MaxTx)
            out_bytes.insert(out_bytes.size(), b);
    endfunction

    function automatic void latch_error(input logic [3:0] code);
        ph      = s5ch_pkg::PH_ERR;
        latched = code;
    endfunction

    function automatic void send_port_bytes();
        emit(cfg_port[15:8]);
        emit(cfg_port[7:0]);
        ph = s5ch_pkg::PH_RVER;
    endfunction

    function automatic void send_connect_request();
        logic [7:0] count;
        case (cfg_kind)
            s5ch_pkg::KIND_HOST: count = cfg_host_len;
            s5ch_pkg::KIND_IPV4: count = 8'd4;
            s5ch_pkg::KIND_IPV6: count = 8'd16;
            default:
            begin
                latch_error(s5ch_pkg::ST_MISUSE);
                return;
            end
        endcase
        emit(s5ch_pkg::B_VERSION);
        emit(s5ch_pkg::B_CMD_CONN);
        emit(s5ch_pkg::B_ZERO);
        if (cfg_kind == s5ch_pkg::KIND_HOST)
        begin
            emit(s5ch_pkg::B_AT_HOST);
            emit(cfg_host_len);
        end
        else
            emit(cfg_kind == s5ch_pkg::KIND_IPV4 ? s5ch_pkg::B_AT_IPV4 : s5ch_pkg::B_AT_IPV6);
        if (count == 8'd0)
            send_port_bytes();
        else
        begin
            ph   = s5ch_pkg::PH_DEST;
            left = count;
        end
    endfunction

    function automatic void send_password_len();
        emit(cfg_pass_len);
        if (cfg_pass_len == 8'd0)
            ph = s5ch_pkg::PH_AVER;
        else
        begin
            ph   = s5ch_pkg::PH_PASS;
            left = cfg_pass_len;
        end
    endfunction

    function automatic void take_server_byte(input logic [7:0] d);
        case (ph)
            s5ch_pkg::PH_GVER:
                if (d != s5ch_pkg::B_VERSION) latch_error(s5ch_pkg::ST_UNEXPECTED);
                else ph = s5ch_pkg::PH_GMETH;
            s5ch_pkg::PH_GMETH:
                if (d == s5ch_pkg::B_M_REJECT)
                    latch_error(s5ch_pkg::ST_NO_METHOD);
                else if (d == s5ch_pkg::B_M_NONE)
                    send_connect_request();
                else if (d == s5ch_pkg::B_M_USERPW)
                begin
                    if (!cfg_creds)
                        latch_error(s5ch_pkg::ST_NEED_CREDS);
                    else
                    begin
                        emit(s5ch_pkg::B_AUTH_VER);
                        emit(cfg_user_len);
                        if (cfg_user_len == 8'd0)
                            send_password_len();
                        else
                        begin
                            ph   = s5ch_pkg::PH_USER;
                            left = cfg_user_len;
                        end
                    end
                end
                else
                    latch_error(s5ch_pkg::ST_BAD_METHOD);
            s5ch_pkg::PH_AVER:
                if (d != s5ch_pkg::B_AUTH_VER) latch_error(s5ch_pkg::ST_UNEXPECTED);
                else ph = s5ch_pkg::PH_AST;
            s5ch_pkg::PH_AST:
                if (d != s5ch_pkg::B_ZERO) latch_error(s5ch_pkg::ST_AUTH_REFUSE);
                else send_connect_request();
            s5ch_pkg::PH_RVER:
                if (d != s5ch_pkg::B_VERSION) latch_error(s5ch_pkg::ST_UNEXPECTED);
                else ph = s5ch_pkg::PH_REP;
            s5ch_pkg::PH_REP:
                if (d != s5ch_pkg::B_ZERO) latch_error(s5ch_pkg::ST_CONN_REFUSE);
                else ph = s5ch_pkg::PH_RRSV;
            s5ch_pkg::PH_RRSV:
                if (d != s5ch_pkg::B_ZERO) latch_error(s5ch_pkg::ST_UNEXPECTED);
                else ph = s5ch_pkg::PH_RATYP;
            s5ch_pkg::PH_RATYP:
                if (d == s5ch_pkg::B_AT_IPV4)
                begin
                    ph   = s5ch_pkg::PH_RADDR;
                    left = 8'd4;
                end
                else if (d == s5ch_pkg::B_AT_IPV6)
                begin
                    ph   = s5ch_pkg::PH_RADDR;
                    left = 8'd16;
                end
                else if (d == s5ch_pkg::B_AT_HOST)
                    ph = s5ch_pkg::PH_RLEN;
                else
                    latch_error(s5ch_pkg::ST_UNEXPECTED);
            s5ch_pkg::PH_RLEN:
                if (d == 8'd0)
                begin
                    ph   = s5ch_pkg::PH_RPORT;
                    left = 8'd2;
                end
                else
                begin
                    ph   = s5ch_pkg::PH_RADDR;
                    left = d;
                end
            s5ch_pkg::PH_RADDR:
            begin
                left = left - 8'd1;
                if (left == 8'd0)
                begin
                    ph   = s5ch_pkg::PH_RPORT;
                    left = 8'd2;
                end
            end
            s5ch_pkg::PH_RPORT:
            begin
                left = left - 8'd1;
                if (left == 8'd0)
                begin
                    ph      = s5ch_pkg::PH_DONE;
                    latched = s5ch_pkg::ST_CONNECTED;
                end
            end
            default: latch_error(s5ch_pkg::ST_MISUSE);
        endcase
    endfunction

    function automatic void take_payload_byte(input logic [7:0] d);
        if (ph != s5ch_pkg::PH_USER && ph != s5ch_pkg::PH_PASS && ph != s5ch_pkg::PH_DEST)
        begin
            latch_error(s5ch_pkg::ST_MISUSE);
            return;
        end
        emit(d);
        left = left - 8'd1;
        if (left != 8'd0)
            return;
        if (ph == s5ch_pkg::PH_USER)
            send_password_len();
        else if (ph == s5ch_pkg::PH_PASS)
            ph = s5ch_pkg::PH_AVER;
        else
            send_port_bytes();
    endfunction

    // advance the predicted handshake by one item and queue its transfers
    function automatic void handshake_step(input logic [1:0] op, input logic [7:0] d);
        tx_result_t r;
        int         n;
        out_bytes.delete();
        if (ph != s5ch_pkg::PH_DONE && ph != s5ch_pkg::PH_ERR)
        begin
            case (op)
                s5ch_pkg::OP_START:
                    if (ph != s5ch_pkg::PH_IDLE)
                        latch_error(s5ch_pkg::ST_MISUSE);
                    else
                    begin
                        emit(s5ch_pkg::B_VERSION);
                        emit(cfg_creds ? s5ch_pkg::B_TWO_COUNT : s5ch_pkg::B_ONE_COUNT);
                        emit(s5ch_pkg::B_M_NONE);
                        if (cfg_creds)
                            emit(s5ch_pkg::B_M_USERPW);
                        ph = s5ch_pkg::PH_GVER;
                    end
                s5ch_pkg::OP_SERVER:  take_server_byte(d);
                s5ch_pkg::OP_PAYLOAD: take_payload_byte(d);
                default:              latch_error(s5ch_pkg::ST_MISUSE);
            endcase
        end
        if (ph == s5ch_pkg::PH_USER || ph == s5ch_pkg::PH_PASS || ph == s5ch_pkg::PH_DEST)
            r.want = s5ch_pkg::WANT_PAYLOAD;
        else if (ph == s5ch_pkg::PH_IDLE || ph == s5ch_pkg::PH_DONE || ph == s5ch_pkg::PH_ERR)
            r.want = s5ch_pkg::WANT_NONE;
        else
            r.want = s5ch_pkg::WANT_SERVER;
        r.status = (ph == s5ch_pkg::PH_DONE || ph == s5ch_pkg::PH_ERR) ? latched
                                                                       : s5ch_pkg::ST_BUSY;
        n = (out_bytes.size() > 0) ? out_bytes.size() : 1;
        for (int k = 0; k < n; k++)
        begin
            r.tx_valid = (out_bytes.size() > 0);
            r.tx_byte  = (out_bytes.size() > 0) ? out_bytes[k] : 8'h00;
            r.is_last  = (k == n - 1);
            pending_tx.insert(pending_tx.size(), r);
        end
        step_results = n;
    endfunction

    task automatic report(input string field, input int got, input int exp_v);
        if (mismatches < PrintLimit)
            $display("mismatch at %0t: %s got %0h, predicted %0h", $time, field, got, exp_v);
        mismatches++;
    endtask

    task automatic send_item(input logic [1:0] op, input logic [7:0] d, input bit typed,
                             input logic [1:0] t_want, input logic [3:0] t_status);
        int         gap;
        tx_result_t r;
        gap = (steady || burst_left > 0) ? 0 : $urandom_range(0, 15);
        if (burst_left > 0)
            burst_left--;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = d;
        do @(posedge clk); while (!s_tready);
        handshake_step(op, d);
        // typed rows pin want and status by hand
        if (typed)
        begin
            for (int i = pending_tx.size() - step_results; i < pending_tx.size(); i++)
            begin
                r        = pending_tx[i];
                r.want   = t_want;
                r.status = t_status;
                pending_tx[i] = r;
            end
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] index, input logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            s5ch_pkg::CFG_HAS_CREDS: cfg_creds    = value[0];
            s5ch_pkg::CFG_KIND:      cfg_kind     = value[1:0];
            s5ch_pkg::CFG_PORT:      cfg_port     = value;
            s5ch_pkg::CFG_USER_LEN:  cfg_user_len = value[7:0];
            s5ch_pkg::CFG_PASS_LEN:  cfg_pass_len = value[7:0];
            s5ch_pkg::CFG_HOST_LEN:  cfg_host_len = value[7:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_setting(input logic creds, input logic [1:0] kind,
                                 input logic [15:0] port, input logic [7:0] ulen,
                                 input logic [7:0] plen, input logic [7:0] hlen);
        cfg_write(s5ch_pkg::CFG_HAS_CREDS, {15'd0, creds});
        cfg_write(s5ch_pkg::CFG_KIND, {14'd0, kind});
        cfg_write(s5ch_pkg::CFG_PORT, port);
        cfg_write(s5ch_pkg::CFG_USER_LEN, {8'd0, ulen});
        cfg_write(s5ch_pkg::CFG_PASS_LEN, {8'd0, plen});
        cfg_write(s5ch_pkg::CFG_HOST_LEN, {8'd0, hlen});
    endtask

    task automatic wait_results();
        s_tvalid = 1'b0;
        while (pending_tx.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        @(negedge clk);
    endtask

    // keep the handshake body near the item budget
    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'd0;
        return 8'($urandom_range(1, 24));
    endfunction

    function automatic void push_item(input logic [1:0] op, input logic [7:0] d);
        item_t it;
        it.op   = op;
        it.data = d;
        session_items.insert(session_items.size(), it);
    endfunction

    // rest of the handshake after the server version, random content, mostly well-formed
    function automatic void build_session();
        int          r;
        int          count;
        logic [7:0]  meth;
        logic [7:0]  blen;
        item_t       it;
        fault_t      fault;
        session_items.delete();
        r = $urandom_range(0, 15);
        if (r < 12)
            meth = cfg_creds ? s5ch_pkg::B_M_USERPW : s5ch_pkg::B_M_NONE;
        else if (r == 12)
            meth = cfg_creds ? s5ch_pkg::B_M_NONE : s5ch_pkg::B_M_USERPW;
        else if (r == 13)
            meth = s5ch_pkg::B_M_REJECT;
        else
            meth = 8'($urandom_range(0, 255));
        push_item(s5ch_pkg::OP_SERVER, meth);
        if (meth == s5ch_pkg::B_M_USERPW && cfg_creds)
        begin
            for (int i = 0; i < int'(cfg_user_len); i++)
                push_item(s5ch_pkg::OP_PAYLOAD, 8'($urandom_range(0, 255)));
            for (int i = 0; i < int'(cfg_pass_len); i++)
                push_item(s5ch_pkg::OP_PAYLOAD, 8'($urandom_range(0, 255)));
            push_item(s5ch_pkg::OP_SERVER, s5ch_pkg::B_AUTH_VER);
            push_item(s5ch_pkg::OP_SERVER, s5ch_pkg::B_ZERO);
        end
        case (cfg_kind)
            s5ch_pkg::KIND_HOST: count = int'(cfg_host_len);
            s5ch_pkg::KIND_IPV4: count = 4;
            s5ch_pkg::KIND_IPV6: count = 16;
            default:             count = 0;
        endcase
        for (int i = 0; i < count; i++)
            push_item(s5ch_pkg::OP_PAYLOAD, 8'($urandom_range(0, 255)));
        push_item(s5ch_pkg::OP_SERVER, s5ch_pkg::B_VERSION);
        push_item(s5ch_pkg::OP_SERVER, s5ch_pkg::B_ZERO);
        push_item(s5ch_pkg::OP_SERVER, s5ch_pkg::B_ZERO);
        r = $urandom_range(0, 7);
        if (r < 3)
        begin
            push_item(s5ch_pkg::OP_SERVER, s5ch_pkg::B_AT_IPV4);
            count = 4;
        end
        else if (r < 5)
        begin
            push_item(s5ch_pkg::OP_SERVER, s5ch_pkg::B_AT_IPV6);
            count = 16;
        end
        else if (r < 7)
        begin
            blen = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 20));
            push_item(s5ch_pkg::OP_SERVER, s5ch_pkg::B_AT_HOST);
            push_item(s5ch_pkg::OP_SERVER, blen);
            count = int'(blen);
        end
        else
        begin
            push_item(s5ch_pkg::OP_SERVER, 8'($urandom_range(0, 255)));
            count = 4;
        end
        for (int i = 0; i < count + 2; i++)
            push_item(s5ch_pkg::OP_SERVER, 8'($urandom_range(0, 255)));
        // break the sequence at one random point in about half the runs
        if ($urandom_range(0, 1) == 1)
        begin
            r     = $urandom_range(0, session_items.size() - 1);
            it    = session_items[r];
            fault = fault_t'($urandom_range(0, 3));
            case (fault)
                FAULT_BAD_OP:  it.op = OP_INVALID;
                FAULT_RESTART: it.op = s5ch_pkg::OP_START;
                FAULT_SWAP_OP: it.op = (it.op == s5ch_pkg::OP_SERVER) ? s5ch_pkg::OP_PAYLOAD
                                                                      : s5ch_pkg::OP_SERVER;
                default:       it.data = 8'($urandom_range(0, 255));
            endcase
            session_items[r] = it;
        end
    endfunction

    // output checker
    initial
    begin : result_check
        tx_result_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_tx.size() == 0)
                    report("transfer with nothing pending", int'(m_tdata), 0);
                else
                begin
                    exp_r = pending_tx.pop_front();
                    if (m_tdata[7:0] != exp_r.tx_byte)
                        report("tx_byte", int'(m_tdata[7:0]), int'(exp_r.tx_byte));
                    if (m_tuser != exp_r.tx_valid)
                        report("tx_valid", int'(m_tuser), int'(exp_r.tx_valid));
                    if (m_tdata[9:8] != exp_r.want)
                        report("want", int'(m_tdata[9:8]), int'(exp_r.want));
                    if (m_tdata[13:10] != exp_r.status)
                        report("status", int'(m_tdata[13:10]), int'(exp_r.status));
                    if (m_tlast != exp_r.is_last)
                        report("last_of_run", int'(m_tlast), int'(exp_r.is_last));
                end
                transfers_checked++;
                rx_wait = steady ? 0 : $urandom_range(0, 15);
            end
        end
    end

    // output side ready: per-transfer stalls and one long hold-off on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HoldCycles;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else if (rx_wait > 0)
            begin
                m_tready = 1'b0;
                rx_wait--;
            end
            else
                m_tready = 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < StallLimit)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("socks5_client_handshake_test: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int          r;
        int          hold_at;
        int          pause_at;
        int          steady_lo;
        logic [1:0]  kind;
        logic [15:0] port;
        logic        run_creds;
        logic [3:0]  run_status;
        item_t       it;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tuser    = s5ch_pkg::OP_START;
        cfg_valid  = 1'b0;
        cfg_index  = s5ch_pkg::CFG_HAS_CREDS;
        cfg_data   = 16'h0000;
        mismatches = 0;
        items_sent = 0;
        transfers_checked = 0;
        cfg_writes = 0;
        rx_wait    = 0;
        burst_left = 0;
        steady     = 1'b0;
        hold_req   = 1'b0;

        ph           = s5ch_pkg::PH_IDLE;
        left         = 8'd0;
        latched      = s5ch_pkg::ST_BUSY;
        cfg_creds    = 1'b0;
        cfg_kind     = s5ch_pkg::KIND_IPV4;
        cfg_port     = 16'h0000;
        cfg_user_len = 8'd0;
        cfg_pass_len = 8'd0;
        cfg_host_len = 8'd0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // top extremes first, then the setting the handshake runs with
        write_setting(1'b1, s5ch_pkg::KIND_IPV6, 16'hFFFF, 8'd255, 8'd255, 8'd255);
        r = $urandom_range(0, 7);
        kind = (r == 7) ? KIND_UNKNOWN : 2'(r % 3);
        r = $urandom_range(0, 7);
        port = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        write_setting(1'($urandom_range(0, 1)), kind, port, pick_len(), pick_len(), pick_len());

        foreach (opening_rows[i])
            send_item(opening_rows[i].op, opening_rows[i].data, opening_rows[i].typed,
                      opening_rows[i].want, opening_rows[i].status);

        build_session();
        hold_at   = session_items.size() / 3;
        pause_at  = (2 * session_items.size()) / 3;
        steady_lo = session_items.size() / 2;
        for (int i = 0; i < session_items.size(); i++)
        begin
            if (i == hold_at)
            begin
                // stall the output and keep feeding until the input backs up
                hold_req   = 1'b1;
                burst_left = 12;
            end
            if (i == pause_at)
                wait_results();
            steady = (i >= steady_lo && i < steady_lo + 16);
            it = session_items[i];
            send_item(it.op, it.data, 1'b0, s5ch_pkg::WANT_NONE, s5ch_pkg::ST_BUSY);
        end
        steady = 1'b0;

        // fill up the item budget with arbitrary items
        while (items_sent < ItemTarget - $size(closing_rows) - 1)
            send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0,
                      s5ch_pkg::WANT_NONE, s5ch_pkg::ST_BUSY);

        foreach (closing_rows[i])
            send_item(closing_rows[i].op, closing_rows[i].data, closing_rows[i].typed,
                      closing_rows[i].want, closing_rows[i].status);

        wait_results();
        run_creds  = cfg_creds;
        run_status = latched;
        write_setting(1'b0, s5ch_pkg::KIND_HOST, 16'h0000, 8'd0, 8'd0, 8'd0);
        send_item(s5ch_pkg::OP_SERVER, 8'hA5, 1'b0, s5ch_pkg::WANT_NONE, s5ch_pkg::ST_BUSY);
        wait_results();

        $display("covered %0d input items (%0d in the handshake body) and %0d output transfers",
                 items_sent, session_items.size(), transfers_checked);
        $display("credentials %0d, destination kind %0d, port %04h; status %0d; %0d errors",
                 run_creds, kind, port, run_status, mismatches);
        if (mismatches == 0)
            $display("socks5_client_handshake_test: PASS");
        else
            $display("socks5_client_handshake_test: FAIL");
        $finish;
    end

endmodule
